>>> hw/rtl/tcd_pkg.sv
// Shared types, constants and helper functions of the timestamp-to-date unit.
`timescale 1ns / 1ps

package tcd_pkg;

    // Field widths of the input and result beats.
    localparam int MS_W    = 42;
    localparam int YEAR_W  = 11;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;

    // Default epoch and the number of year offsets (0 to 136) that 32-bit seconds can reach.
    localparam int EPOCH_YEAR_DEF = 1900;
    localparam int MAX_YEARS      = 137;

    // Internal widths: remainder of a division step, day count, digit counter,
    // and the subtrahend of the shared compare-subtract unit.
    localparam int REM_W  = 10;
    localparam int DAYS_W = 16;
    localparam int CNT_W  = 2;
    localparam int LEN_W  = 10;

    // Long division by the constants, sixteen dividend bits per digit. A digit
    // step divides {remainder, chunk}, which stays below 2^DIGIT_W.
    localparam int CHUNK_W     = 16;
    localparam int DIVD_W      = 48;
    localparam int DIGIT_W     = REM_W + CHUNK_W;
    localparam int RECIP_W     = 22;
    localparam int PROD_W      = DIGIT_W + RECIP_W;
    localparam int MS_CHUNKS   = 3;
    localparam int TIME_CHUNKS = 2;

    // Leap cycle tracking.
    localparam int LEAP_CYC_W = 9;
    localparam int LEAP_CYCLE = 400;

    // Division pass codes.
    localparam logic [1:0] PH_MS   = 2'd0;
    localparam logic [1:0] PH_SEC  = 2'd1;
    localparam logic [1:0] PH_MIN  = 2'd2;
    localparam logic [1:0] PH_HOUR = 2'd3;

    // Month index codes used by the sequencer.
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

    localparam logic [LEN_W-1:0] DAYS_YEAR      = 10'd365;
    localparam logic [LEN_W-1:0] DAYS_LEAP_YEAR = 10'd366;

    typedef struct packed {
        logic [MS_W-1:0] ms_since_epoch;
    } tcd_in_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [MSEC_W-1:0]  millisecond;
    } tcd_out_t;

    // Constant divisor of each division pass.
    function automatic logic [LEN_W-1:0] div_const(input logic [1:0] ph);
        logic [LEN_W-1:0] d;
        case (ph)
            PH_MS:   d = 10'd1000;
            PH_SEC:  d = 10'd60;
            PH_MIN:  d = 10'd60;
            PH_HOUR: d = 10'd24;
            default: d = 10'd24;
        endcase
        return d;
    endfunction

    // Reciprocal of each divisor, floor(2^DIGIT_W / d). The quotient estimate
    // it gives for a digit is exact or one too low.
    function automatic logic [RECIP_W-1:0] div_recip(input logic [1:0] ph);
        logic [RECIP_W-1:0] m;
        case (ph)
            PH_MS:   m = 22'd67108;
            PH_SEC:  m = 22'd1118481;
            PH_MIN:  m = 22'd1118481;
            PH_HOUR: m = 22'd2796202;
            default: m = 22'd2796202;
        endcase
        return m;
    endfunction

    // Number of sixteen-bit digits in each division pass.
    function automatic logic [CNT_W-1:0] div_chunks(input logic [1:0] ph);
        logic [CNT_W-1:0] n;
        case (ph)
            PH_MS:   n = CNT_W'(MS_CHUNKS);
            default: n = CNT_W'(TIME_CHUNKS);
        endcase
        return n;
    endfunction

    // Length of a month, February stretched in leap years.
    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                   input logic leap);
        logic [LEN_W-1:0] len;
        case (idx)
            4'd0:    len = 10'd31;
            4'd1:    len = leap ? 10'd29 : 10'd28;
            4'd2:    len = 10'd31;
            4'd3:    len = 10'd30;
            4'd4:    len = 10'd31;
            4'd5:    len = 10'd30;
            4'd6:    len = 10'd31;
            4'd7:    len = 10'd31;
            4'd8:    len = 10'd30;
            4'd9:    len = 10'd31;
            4'd10:   len = 10'd30;
            4'd11:   len = 10'd31;
            default: len = 10'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/tcd_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
`timescale 1ns / 1ps

interface tcd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/tcd_cmp_sub.sv
// Shared compare-and-subtract unit used by the correction, year and month steps of the sequencer.
`timescale 1ns / 1ps

module tcd_cmp_sub (
    input  logic [tcd_pkg::DAYS_W-1:0] a,
    input  logic [tcd_pkg::LEN_W-1:0]  b,
    output logic                       ge,
    output logic [tcd_pkg::DAYS_W-1:0] diff
);
    import tcd_pkg::*;

    logic [DAYS_W:0] wide_diff;

    // One wide subtract; the borrow bit doubles as the compare result.
    assign wide_diff = {1'b0, a} - {1'b0, DAYS_W'(b)};
    assign ge        = ~wide_diff[DAYS_W];
    assign diff      = wide_diff[DAYS_W-1:0];

endmodule

>>> hw/rtl/timestamp_to_calendar_date_unit.sv
// Top level: millisecond timestamp to Gregorian calendar date and time of day.
`timescale 1ns / 1ps

// Converts a count of milliseconds since EPOCH_YEAR-01-01 00:00:00.000 into
// year, month, day, hour, minute, second and millisecond. The whole-second
// count is kept to 32 bits, so larger inputs wrap before the calendar split.
// One beat is taken at a time: after a stamp beat is accepted the unit stays
// busy until it has stripped the whole years since the epoch (up to 136) and
// walked the months, and the output register is free. The divisions by 1000,
// 60, 60 and 24 run as long division sixteen bits at a time, three digits for
// the first and two for each of the others, and every digit takes three steps:
// a reciprocal multiply for the quotient estimate, the remainder, and a
// correction on the shared compare-subtract unit. That unit then strips one
// year per cycle and one month per cycle. The result sits in an output
// register, so a new stamp beat is taken while the previous date beat still
// waits for the sink.
module timestamp_to_calendar_date_unit #(
    parameter int EPOCH_YEAR = tcd_pkg::EPOCH_YEAR_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tcd_stream_if.sink   stamp,
    tcd_stream_if.source date
);
    import tcd_pkg::*;

    localparam int YR_W = $clog2(EPOCH_YEAR + MAX_YEARS + 1);
    localparam logic [YR_W-1:0]       YEAR0  = YR_W'(EPOCH_YEAR);
    localparam logic [LEAP_CYC_W-1:0] CYC0   = LEAP_CYC_W'(EPOCH_YEAR % LEAP_CYCLE);
    localparam logic [LEAP_CYC_W-1:0] CYC_LAST = LEAP_CYC_W'(LEAP_CYCLE - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_REM   = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVD_W-1:0]     q_reg, q_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [CHUNK_W-1:0]    qe_reg, qe_next;
    logic [REM_W:0]        r_reg, r_next;
    logic [DAYS_W-1:0]     days_reg, days_next;
    logic [YR_W-1:0]       year_reg, year_next;
    logic [LEAP_CYC_W-1:0] cyc_reg, cyc_next;
    logic [MONTH_W-1:0]    mon_reg, mon_next;
    logic [MSEC_W-1:0]     msec_reg, msec_next;
    logic [SEC_W-1:0]      sec_reg, sec_next;
    logic [MIN_W-1:0]      min_reg, min_next;
    logic [HOUR_W-1:0]     hour_reg, hour_next;
    logic                  out_valid_reg, out_valid_next;
    tcd_out_t              out_reg, out_next;

    logic [DIGIT_W-1:0]    digit;
    logic [PROD_W-1:0]     recip_prod;
    logic [DIGIT_W-1:0]    back_prod;
    logic [DIGIT_W-1:0]    rem_est;
    logic [CHUNK_W-1:0]    q_digit;
    logic [REM_W-1:0]      rem_fix;
    logic [DIVD_W-1:0]     q_shift;
    logic [DAYS_W-1:0]     alu_a;
    logic [LEN_W-1:0]      alu_b;
    logic                  alu_ge;
    logic [DAYS_W-1:0]     alu_diff;
    logic                  leap;
    logic                  out_free;
    logic                  month_done;
    tcd_in_t               in_beat;

    assign in_beat = stamp.payload;

    // Leap rule from the position in the 400-year cycle.
    assign leap = (cyc_reg[1:0] == 2'b00)
                  && (cyc_reg != LEAP_CYC_W'(100))
                  && (cyc_reg != LEAP_CYC_W'(200))
                  && (cyc_reg != LEAP_CYC_W'(300));

    // One digit of the long division: the running remainder above the next
    // sixteen dividend bits. The reciprocal estimate is exact or one low.
    assign digit      = {rem_reg, q_reg[DIVD_W-1 -: CHUNK_W]};
    assign recip_prod = {{RECIP_W{1'b0}}, digit} * {{DIGIT_W{1'b0}}, div_recip(phase_reg)};
    assign back_prod  = {{(DIGIT_W-CHUNK_W){1'b0}}, qe_reg}
                        * {{(DIGIT_W-LEN_W){1'b0}}, div_const(phase_reg)};
    assign rem_est    = digit - back_prod;

    // Operand selection for the shared unit.
    always_comb
    begin
        case (state_reg)
            ST_FIX:
            begin
                alu_a = DAYS_W'(r_reg);
                alu_b = div_const(phase_reg);
            end
            ST_YEAR:
            begin
                alu_a = days_reg;
                alu_b = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
            end
            default:
            begin
                alu_a = days_reg;
                alu_b = month_len(mon_reg, leap);
            end
        endcase
    end

    tcd_cmp_sub u_cmp_sub (
        .a    (alu_a),
        .b    (alu_b),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    // Corrected quotient digit and remainder, shifted into the dividend.
    assign q_digit = qe_reg + CHUNK_W'(alu_ge);
    assign rem_fix = alu_ge ? REM_W'(alu_diff) : REM_W'(r_reg);
    assign q_shift = {q_reg[DIVD_W-CHUNK_W-1:0], q_digit};

    assign out_free   = ~out_valid_reg | date.ready;
    assign month_done = (mon_reg == MON_DEC) | ~alu_ge;

    assign stamp.ready  = (state_reg == ST_IDLE);
    assign date.valid   = out_valid_reg;
    assign date.payload = out_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        qe_next        = qe_reg;
        r_next         = r_reg;
        days_next      = days_reg;
        year_next      = year_reg;
        cyc_next       = cyc_reg;
        mon_next       = mon_reg;
        msec_next      = msec_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~date.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (stamp.valid)
                begin
                    q_next     = DIVD_W'(in_beat.ms_since_epoch);
                    rem_next   = '0;
                    phase_next = PH_MS;
                    cnt_next   = div_chunks(PH_MS);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                qe_next    = recip_prod[DIGIT_W +: CHUNK_W];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                r_next     = rem_est[REM_W:0];
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                q_next     = q_shift;
                rem_next   = rem_fix;
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = ST_MUL;
                if (cnt_reg == CNT_W'(1))
                begin
                    // Pass finished: store the remainder in its field, move the low 32
                    // quotient bits to the top of the dividend for the next pass.
                    rem_next   = '0;
                    phase_next = phase_reg + 2'd1;
                    cnt_next   = div_chunks(phase_reg + 2'd1);
                    q_next     = q_shift << CHUNK_W;
                    case (phase_reg)
                        PH_MS:
                        begin
                            msec_next = rem_fix;
                        end
                        PH_SEC:
                        begin
                            sec_next = SEC_W'(rem_fix);
                        end
                        PH_MIN:
                        begin
                            min_next = MIN_W'(rem_fix);
                        end
                        default:
                        begin
                            hour_next  = HOUR_W'(rem_fix);
                            days_next  = q_shift[DAYS_W-1:0];
                            year_next  = YEAR0;
                            cyc_next   = CYC0;
                            state_next = ST_YEAR;
                        end
                    endcase
                end
            end
            ST_YEAR:
            begin
                // Strip one whole year per cycle.
                if (alu_ge)
                begin
                    days_next = alu_diff;
                    year_next = year_reg + YR_W'(1);
                    cyc_next  = (cyc_reg == CYC_LAST) ? '0 : cyc_reg + LEAP_CYC_W'(1);
                end
                else
                begin
                    mon_next   = MON_JAN;
                    state_next = ST_MONTH;
                end
            end
            default:
            begin
                // Walk the month table; December takes whatever is left.
                if (!month_done)
                begin
                    days_next = alu_diff;
                    mon_next  = mon_reg + MONTH_W'(1);
                end
                else if (out_free)
                begin
                    out_next.year        = YEAR_W'(year_reg);
                    out_next.month       = mon_reg + MONTH_W'(1);
                    out_next.day         = days_reg[DAY_W-1:0] + DAY_W'(1);
                    out_next.hour        = hour_reg;
                    out_next.minute      = min_reg;
                    out_next.second      = sec_reg;
                    out_next.millisecond = msec_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MS;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        qe_reg   <= qe_next;
        r_reg    <= r_next;
        days_reg <= days_next;
        year_reg <= year_next;
        cyc_reg  <= cyc_next;
        mon_reg  <= mon_next;
        msec_reg <= msec_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hour_reg <= hour_next;
        out_reg  <= out_next;
    end

endmodule

>>> hw/rtl/tcd_checker.sv
// Port-level assertions for the timestamp-to-date unit, bound to the top level.
`timescale 1ns / 1ps

module tcd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input tcd_pkg::tcd_out_t out_data
);
    import tcd_pkg::*;

    // A date beat that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("date beat changed while stalled");

    // Once a stamp is taken the unit is busy converting it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("stamp taken while a conversion was running");

    // The month stays within 1 to 12 and the day is at least 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.month >= 4'd1 && out_data.month <= 4'd12
                      && out_data.day >= 5'd1)
        else $error("month or day out of range");

    // Time-of-day fields stay inside their ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.hour <= 5'd23 && out_data.minute <= 6'd59
                      && out_data.second <= 6'd59 && out_data.millisecond <= 10'd999)
        else $error("time of day out of range");

endmodule

bind timestamp_to_calendar_date_unit tcd_checker u_tcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stamp.valid),
    .in_ready  (stamp.ready),
    .out_valid (date.valid),
    .out_ready (date.ready),
    .out_data  (date.payload)
);
